// ===== sv/otb_pkg.sv =====
// Shared constants, codes and control/status types of the Otsu binarizer.
// Depends on nothing; otb_dpath, otb_ctrl and the top level import it.
`timescale 1ns / 1ps
package otb_pkg;

  // Histogram geometry (8-bit luma)
  localparam int unsigned LEVELS  = 256;
  localparam int unsigned BIN_AW  = 8;
  localparam int unsigned DEF_MAX_FRAME_PIXELS = 1048576;

  // Result kinds on the output tuser
  localparam logic KIND_PIXEL     = 1'b0;
  localparam logic KIND_THRESHOLD = 1'b1;

  // Input func codes on the input tuser
  localparam logic FUNC_ACCUM    = 1'b0;
  localparam logic FUNC_CLASSIFY = 1'b1;

  // Operand selection of the shared serial multiplier
  typedef enum logic [1:0] {
    MUL_SQ,
    MUL_LHS,
    MUL_RHS
  } mul_sel_e;

  // Controller to datapath commands
  typedef struct packed {
    logic     hist_load;
    logic     cls_load;
    logic     walk_init;
    logic     bin_add;
    logic     prod_calc;
    logic     diff_calc;
    logic     mul_start;
    mul_sel_e mul_sel;
    logic     best_upd;
    logic     t_next;
    logic     thr_load;
  } otb_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_busy;
    logic wb_zero;
    logic wb_ge_wt;
    logic t_last;
    logic mul_done;
  } otb_sts_t;

endpackage

// ===== sv/otb_mul.sv =====
// Shift-and-add multiplier, one multiplier bit per cycle, stops early.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
module otb_mul #(
  parameter int unsigned AW = 100,
  parameter int unsigned BW = 50,
  parameter int unsigned PW = 150
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [AW-1:0] a_i,
  input  logic [BW-1:0] b_i,
  output logic          done_o,
  output logic [PW-1:0] prod_o
);

  logic          busy_q;
  logic [PW-1:0] a_q;
  logic [BW-1:0] b_q;
  logic [PW-1:0] acc_q;

  assign done_o = busy_q && (b_q == '0);
  assign prod_o = acc_q;

  // Track run state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (done_o) begin
      busy_q <= 1'b0;
    end
  end

  // Add shifted multiplicand per set multiplier bit
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= PW'(a_i);
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q && (b_q != '0)) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= a_q << 1;
      b_q <= b_q >> 1;
    end
  end

endmodule

// ===== sv/otb_dpath.sv =====
// Datapath: histogram memory with its update pipeline, bin walk registers,
// variance compare and the output register. Depends on otb_pkg, otb_mul.
`timescale 1ns / 1ps
module otb_dpath #(
  parameter int unsigned MAX_FRAME_PIXELS = otb_pkg::DEF_MAX_FRAME_PIXELS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  otb_pkg::otb_cmd_t               cmd_i,
  output otb_pkg::otb_sts_t               sts_o,
  input  logic [otb_pkg::BIN_AW-1:0]      luma_i,
  input  logic                            opaque_i,
  input  logic                            last_i,
  input  logic                            cfg_we_i,
  input  logic                            cfg_data_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic                            out_kind_o,
  output logic                            out_level_o,
  output logic [otb_pkg::BIN_AW-1:0]      out_thr_o
);
  import otb_pkg::*;

  localparam int unsigned CW  = $clog2(MAX_FRAME_PIXELS + 1);
  localparam int unsigned SW  = CW + BIN_AW;
  localparam int unsigned XW  = SW + CW;
  localparam int unsigned PPW = 2 * CW;
  localparam int unsigned QW  = 2 * XW;
  localparam int unsigned RW  = QW + PPW;
  localparam logic [CW-1:0] MaxPix = CW'(MAX_FRAME_PIXELS);

  // Histogram storage and accumulators
  logic [CW-1:0]     mem_q [LEVELS];
  logic [CW-1:0]     rd_q;
  logic [LEVELS-1:0] vld_q;
  logic [SW-1:0]     sum_q;
  logic [CW-1:0]     tot_q;
  logic              frame_open_q;
  logic              invert_q;

  // Update stage
  logic              s2_v_q;
  logic [BIN_AW-1:0] s2_luma_q;
  logic              s2_opq_q;
  logic              lw_q;
  logic [BIN_AW-1:0] lw_addr_q;
  logic [CW-1:0]     lw_val_q;
  logic [CW-1:0]     cnt_old;
  logic [CW-1:0]     cnt_new;
  logic              wen;
  logic [BIN_AW-1:0] rd_addr;

  // Walk state
  logic [BIN_AW-1:0] t_q;
  logic [CW-1:0]     wb_q;
  logic [SW-1:0]     sb_q;
  logic [XW-1:0]     x_q;
  logic [XW-1:0]     y_q;
  logic [PPW-1:0]    p_q;
  logic [XW-1:0]     d_q;
  logic [QW-1:0]     dsq_q;
  logic [RW-1:0]     lhs_q;
  logic [QW-1:0]     best_dsq_q;
  logic [PPW-1:0]    best_p_q;
  logic [BIN_AW-1:0] best_t_q;
  logic [BIN_AW-1:0] thr_q;
  logic [CW-1:0]     bin_c;

  // Multiplier operands
  logic [QW-1:0]     mul_a;
  logic [XW-1:0]     mul_b;
  logic              mul_done;
  logic [RW-1:0]     mul_prod;

  // Output register
  logic              out_valid_q;
  logic              out_kind_q;
  logic              out_level_q;
  logic [BIN_AW-1:0] out_thr_q;
  logic              cls_level;

  assign rd_addr = cmd_i.hist_load ? luma_i : t_q;
  assign cnt_old = (lw_q && (lw_addr_q == s2_luma_q)) ? lw_val_q
                 : (vld_q[s2_luma_q] ? rd_q : '0);
  assign cnt_new = cnt_old + CW'(1);
  assign wen     = s2_v_q && s2_opq_q && (tot_q < MaxPix);
  assign bin_c   = vld_q[t_q] ? rd_q : '0;

  // Memory write and registered read
  always_ff @(posedge clk_i) begin
    if (wen) begin
      mem_q[s2_luma_q] <= cnt_new;
    end
    rd_q <= mem_q[rd_addr];
  end

  // Frame control, valid bits, sum and total
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q        <= '0;
      sum_q        <= '0;
      tot_q        <= '0;
      frame_open_q <= 1'b0;
      s2_v_q       <= 1'b0;
      lw_q         <= 1'b0;
      invert_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        invert_q <= cfg_data_i;
      end
      s2_v_q <= cmd_i.hist_load;
      lw_q   <= wen;
      if (cmd_i.hist_load) begin
        frame_open_q <= !last_i;
        if (!frame_open_q) begin
          vld_q <= '0;
          sum_q <= '0;
          tot_q <= '0;
        end
      end
      if (wen) begin
        vld_q[s2_luma_q] <= 1'b1;
        sum_q            <= sum_q + SW'(s2_luma_q);
        tot_q            <= tot_q + CW'(1);
      end
    end
  end

  // Capture item for the update stage and remember the last write
  always_ff @(posedge clk_i) begin
    if (cmd_i.hist_load) begin
      s2_luma_q <= luma_i;
      s2_opq_q  <= opaque_i;
    end
    lw_addr_q <= s2_luma_q;
    lw_val_q  <= cnt_new;
  end

  // Pick operands of the serial multiplier
  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_SQ: begin
        mul_a = QW'(d_q);
        mul_b = d_q;
      end
      MUL_LHS: begin
        mul_a = dsq_q;
        mul_b = XW'(best_p_q);
      end
      MUL_RHS: begin
        mul_a = best_dsq_q;
        mul_b = XW'(p_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  otb_mul #(
    .AW(QW),
    .BW(XW),
    .PW(RW)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  // Bin walk: class weights, products, difference and best score
  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_init) begin
      t_q        <= '0;
      wb_q       <= '0;
      sb_q       <= '0;
      best_dsq_q <= '0;
      best_p_q   <= PPW'(1);
      best_t_q   <= '0;
    end
    if (cmd_i.t_next) begin
      t_q <= t_q + BIN_AW'(1);
    end
    if (cmd_i.bin_add) begin
      wb_q <= wb_q + bin_c;
      sb_q <= sb_q + (SW'(t_q) * SW'(bin_c));
    end
    if (cmd_i.prod_calc) begin
      x_q <= XW'(sb_q) * XW'(tot_q);
      y_q <= XW'(sum_q) * XW'(wb_q);
      p_q <= PPW'(wb_q) * PPW'(tot_q - wb_q);
    end
    if (cmd_i.diff_calc) begin
      d_q <= (x_q >= y_q) ? (x_q - y_q) : (y_q - x_q);
    end
    if (mul_done && (cmd_i.mul_sel == MUL_SQ)) begin
      dsq_q <= mul_prod[QW-1:0];
    end
    if (mul_done && (cmd_i.mul_sel == MUL_LHS)) begin
      lhs_q <= mul_prod;
    end
    if (cmd_i.best_upd && (lhs_q > mul_prod)) begin
      best_dsq_q <= dsq_q;
      best_p_q   <= p_q;
      best_t_q   <= t_q;
    end
  end

  assign cls_level = (!opaque_i || (luma_i >= thr_q)) ? invert_q : !invert_q;

  // Threshold and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.thr_load) begin
        thr_q       <= best_t_q;
        out_valid_q <= 1'b1;
      end else if (cmd_i.cls_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.thr_load) begin
      out_kind_q  <= KIND_THRESHOLD;
      out_level_q <= 1'b0;
      out_thr_q   <= best_t_q;
    end else if (cmd_i.cls_load) begin
      out_kind_q  <= KIND_PIXEL;
      out_level_q <= cls_level;
      out_thr_q   <= thr_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_level_o = out_level_q;
  assign out_thr_o   = out_thr_q;

  assign sts_o.out_busy = out_valid_q && !out_ready_i;
  assign sts_o.wb_zero  = (wb_q == '0);
  assign sts_o.wb_ge_wt = (wb_q >= tot_q);
  assign sts_o.t_last   = (t_q == BIN_AW'(LEVELS - 1));
  assign sts_o.mul_done = mul_done;

  // A threshold result always carries level zero
  a_thr_level : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_kind_q == KIND_THRESHOLD)) |-> !out_level_q)
    else $error("threshold result with nonzero level");

  // Update stage is empty once the bin walk has started
  a_walk_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.walk_init |=> !s2_v_q)
    else $error("update stage busy during bin walk");

  // No accumulation item is accepted once a multiplication has started
  a_mul_owner : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mul_start |=> !cmd_i.hist_load)
    else $error("item accepted during variance compare");

endmodule

// ===== sv/otb_ctrl.sv =====
// Controller: accepts items and sequences the bin walk of the threshold search.
// Depends on otb_pkg; drives otb_dpath through command and status structs.
`timescale 1ns / 1ps
module otb_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_func_i,
  input  logic                   in_last_i,
  output logic                   in_ready_o,
  input  otb_pkg::otb_sts_t      sts_i,
  output otb_pkg::otb_cmd_t      cmd_o
);
  import otb_pkg::*;

  localparam logic [3:0] S_RUN   = 4'd0;
  localparam logic [3:0] S_DRAIN = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_BIN   = 4'd3;
  localparam logic [3:0] S_CHK   = 4'd4;
  localparam logic [3:0] S_DIFF  = 4'd5;
  localparam logic [3:0] S_SQ0   = 4'd6;
  localparam logic [3:0] S_SQ1   = 4'd7;
  localparam logic [3:0] S_L0    = 4'd8;
  localparam logic [3:0] S_L1    = 4'd9;
  localparam logic [3:0] S_R0    = 4'd10;
  localparam logic [3:0] S_R1    = 4'd11;
  localparam logic [3:0] S_CMP   = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  logic [3:0] state_q;
  logic [3:0] state_d;
  logic       accept;

  assign in_ready_o = (state_q == S_RUN) && !sts_i.out_busy;
  assign accept     = in_valid_i && in_ready_o;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.mul_sel = MUL_SQ;
    unique case (state_q)
      S_RUN: begin
        if (accept) begin
          if (in_func_i == FUNC_CLASSIFY) begin
            cmd_o.cls_load = 1'b1;
          end else begin
            cmd_o.hist_load = 1'b1;
            if (in_last_i) begin
              state_d = S_DRAIN;
            end
          end
        end
      end
      S_DRAIN: begin
        cmd_o.walk_init = 1'b1;
        state_d = S_RD;
      end
      S_RD: begin
        state_d = S_BIN;
      end
      S_BIN: begin
        cmd_o.bin_add = 1'b1;
        state_d = S_CHK;
      end
      S_CHK: begin
        if (sts_i.wb_zero) begin
          if (sts_i.t_last) begin
            state_d = S_OUT;
          end else begin
            cmd_o.t_next = 1'b1;
            state_d = S_RD;
          end
        end else if (sts_i.wb_ge_wt) begin
          state_d = S_OUT;
        end else begin
          cmd_o.prod_calc = 1'b1;
          state_d = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd_o.diff_calc = 1'b1;
        state_d = S_SQ0;
      end
      S_SQ0: begin
        cmd_o.mul_start = 1'b1;
        state_d = S_SQ1;
      end
      S_SQ1: begin
        if (sts_i.mul_done) begin
          state_d = S_L0;
        end
      end
      S_L0: begin
        cmd_o.mul_sel   = MUL_LHS;
        cmd_o.mul_start = 1'b1;
        state_d = S_L1;
      end
      S_L1: begin
        cmd_o.mul_sel = MUL_LHS;
        if (sts_i.mul_done) begin
          state_d = S_R0;
        end
      end
      S_R0: begin
        cmd_o.mul_sel   = MUL_RHS;
        cmd_o.mul_start = 1'b1;
        state_d = S_R1;
      end
      S_R1: begin
        cmd_o.mul_sel = MUL_RHS;
        if (sts_i.mul_done) begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        cmd_o.mul_sel  = MUL_RHS;
        cmd_o.best_upd = 1'b1;
        if (sts_i.t_last) begin
          state_d = S_OUT;
        end else begin
          cmd_o.t_next = 1'b1;
          state_d = S_RD;
        end
      end
      S_OUT: begin
        if (!sts_i.out_busy) begin
          cmd_o.thr_load = 1'b1;
          state_d = S_RUN;
        end
      end
      default: begin
        state_d = S_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_RUN;
    end else begin
      state_q <= state_d;
    end
  end

  // Walk always begins after the closing item of a frame
  a_walk_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAIN) |-> $past(cmd_o.hist_load && in_last_i))
    else $error("bin walk without closing item");

  // Threshold result is loaded only into a free output slot
  a_thr_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.thr_load |-> !sts_i.out_busy)
    else $error("threshold load over pending result");

  // Nothing is accepted while the walk runs
  a_walk_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_RUN) |-> !cmd_o.hist_load && !cmd_o.cls_load)
    else $error("item accepted during bin walk");

endmodule

// ===== sv/otsu_threshold_binarizer.sv =====
// Otsu binarizer, 8-bit luma. Pass 0 items (tuser[0]=0) build a histogram of opaque
// pixels at one item per cycle while the output is not stalled; the item with tlast
// starts a bin walk that stalls the input and ends with one threshold result. The walk
// visits the bins from 0 up in read, add and check steps; a bin with both classes
// populated adds three shift-add multiplications on the shared serial multiplier (one
// multiplier bit per cycle, multiplier operands of up to 2*CW+8 bits). The walk ends at
// bin 255 or once the lower class holds every pixel. Pass 1 items (tuser[0]=1) are
// classified at one item per cycle against the stored threshold while output is free.
// Depends on otb_pkg, otb_ctrl, otb_dpath, otb_mul.
`timescale 1ns / 1ps
module otsu_threshold_binarizer #(
  parameter int unsigned MAX_FRAME_PIXELS = otb_pkg::DEF_MAX_FRAME_PIXELS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] luma
  input  logic [1:0]  s_axis_tuser,   // [0] func, [1] opaque
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [0] level, [8:1] threshold, [15:9] zero
  output logic [0:0]  m_axis_tuser,   // [0] kind
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i
);
  import otb_pkg::*;

  otb_cmd_t          cmd;
  otb_sts_t          sts;
  logic              out_kind;
  logic              out_level;
  logic [BIN_AW-1:0] out_thr;

  assign cfg_ready_o = 1'b1;

  otb_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_func_i (s_axis_tuser[0]),
    .in_last_i (s_axis_tlast),
    .in_ready_o(s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  otb_dpath #(
    .MAX_FRAME_PIXELS(MAX_FRAME_PIXELS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .luma_i     (s_axis_tdata),
    .opaque_i   (s_axis_tuser[1]),
    .last_i     (s_axis_tlast),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_kind_o (out_kind),
    .out_level_o(out_level),
    .out_thr_o  (out_thr)
  );

  // Pack result fields
  assign m_axis_tdata = {7'b0, out_thr, out_level};
  assign m_axis_tuser = out_kind;

  // Closing accumulation item stalls the input for the walk
  a_close_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == FUNC_ACCUM) && s_axis_tlast)
    |=> !s_axis_tready)
    else $error("input not stalled after closing item");

  // Classification item yields a pixel result in the next cycle
  a_cls_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == FUNC_CLASSIFY))
    |=> (m_axis_tvalid && (m_axis_tuser[0] == KIND_PIXEL)))
    else $error("missing pixel result");

  // Accumulation item that does not close a frame yields nothing new
  a_accum_silent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == FUNC_ACCUM) && !s_axis_tlast
     && !m_axis_tvalid) |=> !m_axis_tvalid)
    else $error("result from open accumulation item");

endmodule
